// File: sv/tv_luma_blur_line_fader_macros.svh
// ---------------------------------------------------------------------------
// tv_luma_blur_line_fader assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TV_LUMA_BLUR_LINE_FADER_MACROS_SVH
`define TV_LUMA_BLUR_LINE_FADER_MACROS_SVH

// same-cycle implication
`define TVLB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tvlb assertion failed");

// next-cycle implication
`define TVLB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tvlb assertion failed");

`endif

// File: sv/tvlb_pkg.sv
// ---------------------------------------------------------------------------
// tvlb_pkg
// Types, constants and the luma blur kernel of the luma blur line fader.
// ---------------------------------------------------------------------------
`default_nettype none

package tvlb_pkg;

  localparam int LINE_PIXELS_DEF = 1024;
  localparam logic [7:0] CHROMA_NEUTRAL = 8'h80;

  typedef struct packed {
    logic [7:0] luma_in;
    logic [7:0] chroma_in;
    logic       line_start;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0] luma_out;
    logic [7:0] chroma_out;
  } out_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma;
  } entry_t;

  // (9*y + 4*y1 + 2*y2 + y4) >> 4
  function automatic logic [7:0] blur(input logic [7:0] y, input logic [7:0] y1,
                                      input logic [7:0] y2, input logic [7:0] y4);
    logic [11:0] s;
    s = ({4'b0, y} << 3) + {4'b0, y} + ({4'b0, y1} << 2) + ({4'b0, y2} << 1)
        + {4'b0, y4};
    return s[11:4];
  endfunction

endpackage

`default_nettype wire

// File: sv/tvlb_ram.sv
// ---------------------------------------------------------------------------
// tvlb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module tvlb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = tvlb_pkg::LINE_PIXELS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/tv_luma_blur_line_fader.sv
// ---------------------------------------------------------------------------
// tv_luma_blur_line_fader
// Horizontal luma blur plus line-to-line fader against a one-line store.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one YUV pixel per transfer (luma, chroma, line_start, frame_start).
//   out_* : one faded pixel per input transfer, in input order.
//   A pixel passes the input stage, then the output register; throughput
//   is 1 pixel per cycle while out_ready is high. The line store is a
//   single RAM with a registered read issued at the input transfer and the
//   write-back done when the pixel moves into the output register; a
//   one-entry bypass covers a read of the column written in the same cycle.
//   Store entries not written since frame start read as luma 0, chroma
//   0x80; a fill count of the columns written since frame start tracks
//   this, so no clearing pass is needed.
//   Reset: synchronous, active low; empties both stages, clears history,
//   column and fill count. The block takes input in the first cycle after.
//   Stall: while out_ready is low the output holds; one more pixel waits in
//   the input stage, then in_ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module tv_luma_blur_line_fader #(
  parameter int LINE_PIXELS = tvlb_pkg::LINE_PIXELS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tvlb_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tvlb_pkg::out_t       out_data
);

  localparam int COL_W  = $clog2(LINE_PIXELS);
  localparam int FILL_W = $clog2(LINE_PIXELS + 1);

  logic                in_fire;
  logic                move;
  logic                new_line;
  logic [COL_W-1:0]    col;
  logic [3:0][7:0]     hist_use;
  logic [7:0]          blur;
  logic [FILL_W-1:0]   fill_base;
  logic [FILL_W-1:0]   col_ext;
  logic                sv_in;

  logic [COL_W-1:0]    column_r, column_nxt;
  logic [3:0][7:0]     hist_r, hist_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;

  logic                s0_vld_r;
  logic [COL_W-1:0]    s0_col_r;
  logic [7:0]          s0_blur_r;
  logic [7:0]          s0_chroma_r;
  logic                s0_sv_r;

  logic                fwd_vld_r;
  logic [COL_W-1:0]    fwd_col_r;
  tvlb_pkg::entry_t    fwd_r;

  logic                out_vld_r;
  tvlb_pkg::out_t      out_r;

  tvlb_pkg::entry_t    ram_rd;
  tvlb_pkg::entry_t    prev;
  tvlb_pkg::entry_t    res;
  logic                hit;

  assign move     = s0_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s0_vld_r || move;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    new_line   = in_data.line_start | in_data.frame_start;
    col        = new_line ? '0 : column_r;
    column_nxt = (col == COL_W'(LINE_PIXELS - 1)) ? '0 : col + 1'b1;
    hist_use   = new_line ? '0 : hist_r;
    hist_nxt   = {hist_use[2:0], in_data.luma_in};
    blur       = tvlb_pkg::blur(in_data.luma_in, hist_use[0], hist_use[1], hist_use[3]);
    fill_base  = in_data.frame_start ? '0 : fill_r;
    col_ext    = FILL_W'(col) + 1'b1;
    fill_nxt   = (col_ext > fill_base) ? col_ext : fill_base;
    sv_in      = !in_data.frame_start && (FILL_W'(col) < fill_r);
  end

  tvlb_ram #(
    .WIDTH ($bits(tvlb_pkg::entry_t)),
    .DEPTH (LINE_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (move),
    .waddr (s0_col_r),
    .wdata (res),
    .re    (in_fire),
    .raddr (col),
    .rdata (ram_rd)
  );

  always_comb begin
    hit = fwd_vld_r && (fwd_col_r == s0_col_r);
    if (!s0_sv_r) begin
      prev.luma   = 8'h00;
      prev.chroma = tvlb_pkg::CHROMA_NEUTRAL;
    end else if (hit) begin
      prev = fwd_r;
    end else begin
      prev = ram_rd;
    end
    res.luma   = (s0_blur_r >> 1) + (prev.luma >> 1);
    res.chroma = (s0_chroma_r >> 1) + (prev.chroma >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      fwd_vld_r <= 1'b0;
      column_r  <= '0;
      hist_r    <= '0;
      fill_r    <= '0;
    end else begin
      if (in_fire) begin
        column_r <= column_nxt;
        hist_r   <= hist_nxt;
        fill_r   <= fill_nxt;
      end
      if (in_fire) begin
        s0_vld_r <= 1'b1;
      end else if (move) begin
        s0_vld_r <= 1'b0;
      end
      if (move) begin
        out_vld_r <= 1'b1;
        fwd_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_col_r    <= col;
      s0_blur_r   <= blur;
      s0_chroma_r <= in_data.chroma_in;
      s0_sv_r     <= sv_in;
    end
    if (move) begin
      fwd_col_r          <= s0_col_r;
      fwd_r              <= res;
      out_r.luma_out     <= res.luma;
      out_r.chroma_out   <= res.chroma;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: sv/tvlb_checker.sv
// ---------------------------------------------------------------------------
// tvlb_checker
// Port-level checks of the luma blur line fader, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tv_luma_blur_line_fader_macros.svh"

module tvlb_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire tvlb_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire tvlb_pkg::out_t out_data
);

  // hold a stalled result
  `TVLB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // average of two halves never reaches 255
  `TVLB_ASSERT_NOW(a_out_range, out_valid, out_data.luma_out != 8'hFF && out_data.chroma_out != 8'hFF)

  // an accepted transfer is followed by a valid output
  `TVLB_ASSERT_NOW(a_latency, in_valid && in_ready, ##2 out_valid)

  // back-pressure only with a result waiting
  `TVLB_ASSERT_NOW(a_stall_src, !in_ready, out_valid && !out_ready)

endmodule

bind tv_luma_blur_line_fader tvlb_checker u_tvlb_checker (.*);

`default_nettype wire

// File: tb/sv/tv_luma_blur_line_fader_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tv_luma_blur_line_fader_test
// Streams YUV pixels through the luma blur line fader. Both channels idle and
// stall at random. Each faded pixel is checked against a prediction of the
// horizontal luma blur and of the average with the previous line's entry.
// ---------------------------------------------------------------------------
module tv_luma_blur_line_fader_test;

  localparam int COLUMNS       = tvlb_pkg::LINE_PIXELS_DEF;
  localparam int TARGET_PIXELS = 1750;
  localparam int QUIET_LIMIT   = 1000;
  localparam int MAX_SHOWN     = 10;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  tvlb_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  tvlb_pkg::out_t out_data;

  tvlb_pkg::in_t  pixel_queue[$];
  tvlb_pkg::out_t expected_fades[$];

  // blur history, column and line store of the fader
  bit [7:0]    luma_hist[4];
  int unsigned column;
  bit [7:0]    line_luma[COLUMNS];
  bit [7:0]    line_chroma[COLUMNS];
  bit          line_written[COLUMNS];

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int in_gap         = 0;
  int in_burst       = 0;
  bit in_calm        = 1'b0;
  int out_stall      = 0;
  int out_burst      = 0;
  bit out_calm       = 1'b0;

  tv_luma_blur_line_fader dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic tvlb_pkg::out_t fade_pixel(input tvlb_pkg::in_t px);
    int unsigned    col;
    int unsigned    blurred;
    bit [7:0]       prev_y;
    bit [7:0]       prev_c;
    tvlb_pkg::out_t res;
    if (px.frame_start) begin
      line_written = '{default: 1'b0};
    end
    if (px.frame_start || px.line_start) begin
      luma_hist = '{default: 8'h00};
      column = 0;
    end
    col = column % COLUMNS;
    blurred = (9 * int'(px.luma_in) + 4 * int'(luma_hist[0]) + 2 * int'(luma_hist[1])
               + int'(luma_hist[3])) >> 4;
    if (line_written[col]) begin
      prev_y = line_luma[col];
      prev_c = line_chroma[col];
    end else begin
      prev_y = 8'h00;
      prev_c = tvlb_pkg::CHROMA_NEUTRAL;
    end
    res.luma_out   = (blurred[7:0] >> 1) + (prev_y >> 1);
    res.chroma_out = (px.chroma_in >> 1) + (prev_c >> 1);
    line_luma[col]    = res.luma_out;
    line_chroma[col]  = res.chroma_out;
    line_written[col] = 1'b1;
    luma_hist[3] = luma_hist[2];
    luma_hist[2] = luma_hist[1];
    luma_hist[1] = luma_hist[0];
    luma_hist[0] = px.luma_in;
    column = (col + 1) % COLUMNS;
    return res;
  endfunction

  // idle length for one side: runs of calm stretches and busy stretches
  function automatic int idle_len(inout int burst, inout bit calm);
    int r;
    if (burst == 0) begin
      burst = $urandom_range(40, 300);
      calm  = ($urandom_range(0, 2) == 0);
    end
    burst--;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit [7:0] rand_byte();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_pixel(input bit [7:0] y, input bit [7:0] c, input bit ls,
                             input bit fs);
    tvlb_pkg::in_t px;
    px.luma_in     = y;
    px.chroma_in   = c;
    px.line_start  = ls;
    px.frame_start = fs;
    pixel_queue.push_back(px);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_fades.push_back(fade_pixel(in_data));
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          in_data  <= pixel_queue.pop_front();
          in_valid <= 1'b1;
          in_gap = idle_len(in_burst, in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    tvlb_pkg::out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_fades.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN) begin
            $display("%0t: transfer with nothing expected: luma %0d chroma %0d", $time,
                     out_data.luma_out, out_data.chroma_out);
          end
        end else begin
          want = expected_fades.pop_front();
          if (out_data.luma_out !== want.luma_out ||
              out_data.chroma_out !== want.chroma_out) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN) begin
              $display("%0t: mismatch: expected luma %0d chroma %0d, got luma %0d chroma %0d",
                       $time, want.luma_out, want.chroma_out, out_data.luma_out,
                       out_data.chroma_out);
            end
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall = idle_len(out_burst, out_calm);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int  r;
    int  len;
    bit  ls;
    bit  fs;
    bit  wrapped;
    wrapped = 1'b0;
    column  = 0;

    // saturate the store, then read it back on the next line
    queue_pixel(8'hFF, 8'hFF, 1'b0, 1'b1);
    repeat (4) queue_pixel(8'hFF, 8'hFF, 1'b0, 1'b0);
    queue_pixel(8'hFF, 8'hFF, 1'b1, 1'b0);
    repeat (4) queue_pixel(8'hFF, 8'hFF, 1'b0, 1'b0);
    // both flags: store reads as neutral again
    queue_pixel(8'h00, 8'h00, 1'b1, 1'b1);
    repeat (2) queue_pixel(8'h00, 8'h00, 1'b0, 1'b0);
    queue_pixel(8'h55, 8'hAA, 1'b1, 1'b0);
    queue_pixel(8'hAA, 8'h55, 1'b0, 1'b0);
    queue_pixel(8'h01, 8'hFE, 1'b0, 1'b0);
    // frame start in mid-line without line start
    queue_pixel(8'hFE, 8'h01, 1'b0, 1'b1);
    queue_pixel(8'h80, 8'h7F, 1'b0, 1'b0);
    queue_pixel(8'h7F, 8'h80, 1'b0, 1'b0);

    while (pixel_queue.size() < TARGET_PIXELS) begin
      if (!wrapped && pixel_queue.size() > 400) begin
        // line longer than the store: column wraps, history carries on
        queue_pixel(rand_byte(), rand_byte(), 1'b1, 1'b0);
        repeat (COLUMNS + 24) queue_pixel(rand_byte(), rand_byte(), 1'b0, 1'b0);
        wrapped = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 75) begin
        ls = 1'b1;
        fs = 1'b0;
      end else if (r < 90) begin
        ls = 1'($urandom_range(0, 1));
        fs = 1'b1;
      end else begin
        ls = 1'b0;
        fs = 1'b0;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 160) : $urandom_range(1, 48);
      queue_pixel(rand_byte(), rand_byte(), ls, fs);
      repeat (len - 1) begin
        if ($urandom_range(0, 49) == 0) begin
          r = $urandom_range(0, 3);
          queue_pixel(rand_byte(), rand_byte(), r[0], r[1]);
        end else begin
          queue_pixel(rand_byte(), rand_byte(), 1'b0, 1'b0);
        end
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pixel_queue.size() > 0 || in_valid || expected_fades.size() > 0);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/tvlb_pkg.sv
sv/tvlb_ram.sv
sv/tv_luma_blur_line_fader.sv
sv/tvlb_checker.sv
tb/sv/tv_luma_blur_line_fader_test.sv
